### hdl/unicode_stream_decoder_macros.svh
// Assertion helpers used by the top-level decoder file.
`ifndef UNICODE_STREAM_DECODER_MACROS_SVH
`define UNICODE_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define USD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well.
`define USD_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/usd_pkg.sv
package usd_pkg;

    // Byte order / encoding selection
    typedef enum logic [2:0] {
        ENC_UTF8  = 3'd0,
        ENC_U16BE = 3'd1,
        ENC_U16LE = 3'd2,
        ENC_U32BE = 3'd3,
        ENC_U32LE = 3'd4
    } t_enc;

    // Result status codes
    typedef enum logic [2:0] {
        ST_CHAR      = 3'd0,
        ST_END       = 3'd1,
        ST_BAD_LEAD  = 3'd2,
        ST_BAD_TRAIL = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_BAD_CP    = 3'd5,
        ST_OVERLONG  = 3'd6
    } t_status;

    // Register indexes on the configuration port
    localparam logic REG_ENCODING = 1'b0;
    localparam logic REG_BOM      = 1'b1;

    localparam int USD_QUEUE_DEPTH = 2;

    localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;
    localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;

    // Classified byte as it travels from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
        logic [2:0] u8_len;
        logic       is_trail;
    } t_item;

    // Configuration as seen by the back end
    typedef struct packed {
        logic restart;
        t_enc enc;
        logic bom;
    } t_ctl;

    // Unused register codes fall back to UTF-8
    function automatic t_enc eff_enc(input logic [2:0] code);
        t_enc r;
        unique case (code)
            3'd1:    r = ENC_U16BE;
            3'd2:    r = ENC_U16LE;
            3'd3:    r = ENC_U32BE;
            3'd4:    r = ENC_U32LE;
            default: r = ENC_UTF8;
        endcase
        return r;
    endfunction

    function automatic t_enc swap_enc(input t_enc e);
        t_enc r;
        unique case (e)
            ENC_U16BE: r = ENC_U16LE;
            ENC_U16LE: r = ENC_U16BE;
            ENC_U32BE: r = ENC_U32LE;
            ENC_U32LE: r = ENC_U32BE;
            default:   r = e;
        endcase
        return r;
    endfunction

    // Sequence length from a UTF-8 lead byte, zero for a continuation byte or F8 and up
    function automatic logic [2:0] utf8_len(input logic [7:0] b);
        logic [2:0] r;
        priority if (b < 8'h80) r = 3'd1;
        else if (b < 8'hC0)     r = 3'd0;
        else if (b < 8'hE0)     r = 3'd2;
        else if (b < 8'hF0)     r = 3'd3;
        else if (b < 8'hF8)     r = 3'd4;
        else                    r = 3'd0;
        return r;
    endfunction

endpackage

### hdl/usd_if.sv
// Byte input channel
interface usd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, data_byte, end_of_stream, input ready);
    modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

// Decoded result channel
interface usd_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  status;

    modport source (output valid, code_point, status, input ready);
    modport sink   (input valid, code_point, status, output ready);
endinterface

### hdl/unicode_stream_decoder.sv
// Channel   Dir  Payload                          Transfer
// i_in      in   data_byte[7:0], end_of_stream    valid && ready
// o_out     out  code_point[20:0], status[2:0]    valid && ready
// cfg       in   APB, paddr 0 encoding, 4 bom     psel && penable && pwrite
//
// One byte per clock sustained while o_out is not stalled; a result is presented on
// o_out once its byte has passed the input register, the queue and the output register.
// The byte decode itself is combinational in the back end; stalls on o_out
// fill the queue and then drop i_in.ready.
// i_rst_n is synchronous: encoding UTF-8, BOM detection off, queue empty.
// Writing the encoding register restarts the sequence state with no result.
`include "unicode_stream_decoder_macros.svh"

module unicode_stream_decoder #(
    parameter int QUEUE_DEPTH = usd_pkg::USD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    usd_in_if.sink      i_in,
    usd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import usd_pkg::*;

    logic [2:0] r_encoding;
    logic       r_bom;
    logic       cfg_wr;
    t_ctl       ctl;
    logic       fr_valid;
    t_item      fr_item;
    logic       q_full;
    logic       q_valid;
    t_item      q_item;
    logic       q_pop;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BOM) ? {31'd0, r_bom} : {29'd0, r_encoding};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding <= 3'd0;
            r_bom      <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ENCODING) begin
                r_encoding <= pwdata[2:0];
            end else begin
                r_bom <= pwdata[0];
            end
        end
    end

    // Restart takes the value being written
    assign ctl.restart = cfg_wr && (paddr[2] == REG_ENCODING);
    assign ctl.enc     = ctl.restart ? eff_enc(pwdata[2:0]) : eff_enc(r_encoding);
    assign ctl.bom     = r_bom;

    usd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_valid (fr_valid),
        .o_item  (fr_item)
    );

    usd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_wdata (fr_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_item),
        .i_pop   (q_pop)
    );

    usd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    `USD_ASSERT_NOW(a_zero_cp_on_status, i_clk, i_rst_n, o_out.valid && o_out.status != ST_CHAR, o_out.code_point == '0, "code point not zero on a status result")
    `USD_ASSERT_NOW(a_scalar_range, i_clk, i_rst_n, o_out.valid && o_out.status == ST_CHAR, o_out.code_point <= CP_MAX && o_out.code_point[20:11] != 10'h1B, "character is not a scalar value")
    `USD_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out.valid, "result valid after reset")
endmodule

### hdl/usd_front.sv
module usd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    usd_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_valid,
    output usd_pkg::t_item o_item
);
    import usd_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  push;

    // Move the held byte on whenever the queue has room
    assign push       = r_valid && !i_full;
    assign i_in.ready = !r_valid || !i_full;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    // Hold valid until the byte is pushed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    // Classify the byte on the way in
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte     <= i_in.data_byte;
            r_item.end_of_stream <= i_in.end_of_stream;
            r_item.u8_len        <= utf8_len(i_in.data_byte);
            r_item.is_trail      <= (i_in.data_byte[7:6] == 2'b10);
        end
    end
endmodule

### hdl/usd_fifo.sv
module usd_fifo #(
    parameter int DEPTH = usd_pkg::USD_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  usd_pkg::t_item i_wdata,
    output logic           o_full,
    output logic           o_valid,
    output usd_pkg::t_item o_rdata,
    input  logic           i_pop
);
    import usd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end
endmodule

### hdl/usd_back.sv
module usd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  usd_pkg::t_ctl  i_ctl,
    input  logic           i_valid,
    input  usd_pkg::t_item i_item,
    output logic           o_pop,
    usd_out_if.source      o_out
);
    import usd_pkg::*;

    logic [23:0] r_unit;
    logic [2:0]  r_held;
    logic [2:0]  r_expected;
    t_enc        r_enc;
    logic        r_first;
    logic        r_out_valid;
    logic [20:0] r_out_cp;
    t_status     r_out_st;

    logic [23:0] n_unit;
    logic [2:0]  n_held;
    logic [2:0]  n_expected;
    t_enc        n_enc;
    logic        n_first;

    logic        take;
    logic [7:0]  b;
    logic [7:0]  lead;
    logic [7:0]  second;
    logic [15:0] u16_first;
    logic [15:0] u16_hi;
    logic [15:0] u16_lo;
    logic [31:0] u32_val;
    logic        is_char;
    logic        is_err;
    logic        drop;
    t_status     err_st;
    logic [20:0] char_cp;
    logic        res_valid;
    logic [20:0] res_cp;
    t_status     res_st;

    assign take  = i_valid && (!r_out_valid || o_out.ready);
    assign o_pop = take;
    assign b     = i_item.data_byte;

    // Pick lead and second byte of a finished UTF-8 sequence
    always_comb begin
        unique case (r_expected)
            3'd3:    begin lead = r_unit[15:8];  second = r_unit[7:0];  end
            3'd4:    begin lead = r_unit[23:16]; second = r_unit[15:8]; end
            default: begin lead = r_unit[7:0];   second = b;            end
        endcase
    end

    // Assemble 16- and 32-bit units in either byte order
    always_comb begin
        if (r_enc == ENC_U16LE) begin
            u16_first = {b, r_unit[7:0]};
            u16_hi    = {r_unit[15:8], r_unit[23:16]};
            u16_lo    = {b, r_unit[7:0]};
        end else begin
            u16_first = {r_unit[7:0], b};
            u16_hi    = r_unit[23:8];
            u16_lo    = {r_unit[7:0], b};
        end
        if (r_enc == ENC_U32LE) begin
            u32_val = {b, r_unit[7:0], r_unit[15:8], r_unit[23:16]};
        end else begin
            u32_val = {r_unit, b};
        end
    end

    // Decode one byte against the sequence state
    always_comb begin
        n_unit     = {r_unit[15:0], b};
        n_held     = r_held + 3'd1;
        n_expected = r_expected;
        n_enc      = r_enc;
        n_first    = r_first;
        is_char    = 1'b0;
        is_err     = 1'b0;
        err_st     = ST_CHAR;
        char_cp    = '0;
        drop       = 1'b0;

        unique case (r_enc)
            ENC_U16BE, ENC_U16LE: begin
                if (r_held == 3'd0) begin
                    n_expected = 3'd2;
                end else if (r_held == 3'd1) begin
                    if (u16_first[15:10] == 6'b110111) begin
                        is_err = 1'b1;
                        err_st = ST_BAD_LEAD;
                    end else if (u16_first[15:10] == 6'b110110) begin
                        n_expected = 3'd4;
                    end else begin
                        is_char = 1'b1;
                        char_cp = {5'd0, u16_first};
                    end
                end else if (r_held == 3'd3) begin
                    if (u16_lo[15:10] != 6'b110111) begin
                        is_err = 1'b1;
                        err_st = ST_BAD_TRAIL;
                    end else begin
                        is_char = 1'b1;
                        char_cp = {1'b0, u16_hi[9:0], u16_lo[9:0]} + 21'h10000;
                    end
                end
            end
            ENC_U32BE, ENC_U32LE: begin
                if (r_held == 3'd3) begin
                    if (u32_val > {11'd0, CP_MAX} || u32_val[31:11] == 21'h1B) begin
                        is_err = 1'b1;
                        err_st = ST_BAD_CP;
                    end else begin
                        is_char = 1'b1;
                        char_cp = u32_val[20:0];
                    end
                end
            end
            default: begin
                if (r_held == 3'd0) begin
                    if (i_item.u8_len == 3'd0) begin
                        is_err = 1'b1;
                        err_st = ST_BAD_LEAD;
                    end else if (i_item.u8_len == 3'd1) begin
                        is_char = 1'b1;
                        char_cp = {13'd0, b};
                    end else begin
                        n_expected = i_item.u8_len;
                    end
                end else if (!i_item.is_trail) begin
                    is_err = 1'b1;
                    err_st = ST_BAD_TRAIL;
                end else if (n_held == r_expected) begin
                    if ((lead == 8'hED && second > 8'h9F) ||
                        (lead == 8'hF4 && second > 8'h8F) || lead > 8'hF4) begin
                        is_err = 1'b1;
                        err_st = ST_BAD_CP;
                    end else if (lead < 8'hC2 || (lead == 8'hE0 && second < 8'hA0) ||
                                 (lead == 8'hF0 && second < 8'h90)) begin
                        is_err = 1'b1;
                        err_st = ST_OVERLONG;
                    end else begin
                        is_char = 1'b1;
                        unique case (r_expected)
                            3'd2:    char_cp = {10'd0, lead[4:0], b[5:0]};
                            3'd3:    char_cp = {5'd0, lead[3:0], second[5:0], b[5:0]};
                            default: char_cp = {lead[2:0], second[5:0], r_unit[5:0],
                                                b[5:0]};
                        endcase
                    end
                end
            end
        endcase

        // Close the sequence on a character or an error
        if (is_char || is_err) begin
            n_held     = 3'd0;
            n_expected = 3'd0;
            n_first    = 1'b0;
        end

        // Drop a leading byte order mark, flipping byte order when swapped
        if (is_char && r_first && i_ctl.bom) begin
            if (char_cp == {5'd0, BOM_NATIVE}) begin
                drop = 1'b1;
            end else if (char_cp == {5'd0, BOM_SWAPPED} && r_enc != ENC_UTF8) begin
                drop  = 1'b1;
                n_enc = swap_enc(r_enc);
            end
        end

        res_valid = is_err || (is_char && !drop);
        res_cp    = is_char ? char_cp : '0;
        res_st    = is_err ? err_st : ST_CHAR;

        // End of stream restarts everything
        if (i_item.end_of_stream) begin
            n_held     = 3'd0;
            n_expected = 3'd0;
            n_enc      = i_ctl.enc;
            n_first    = 1'b1;
            res_valid  = 1'b1;
            res_cp     = '0;
            res_st     = (r_held != 3'd0) ? ST_TRUNC : ST_END;
        end
    end

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= 3'd0;
            r_expected <= 3'd0;
            r_enc      <= ENC_UTF8;
            r_first    <= 1'b1;
        end else if (i_ctl.restart) begin
            r_held     <= 3'd0;
            r_expected <= 3'd0;
            r_enc      <= i_ctl.enc;
            r_first    <= 1'b1;
        end else if (take) begin
            r_held     <= n_held;
            r_expected <= n_expected;
            r_enc      <= n_enc;
            r_first    <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_unit <= n_unit;
        end
    end

    // Output register: load a new result or drop one that was taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= take && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid && (!r_out_valid || o_out.ready)) begin
            r_out_cp <= res_cp;
            r_out_st <= res_st;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_out_cp;
    assign o_out.status     = r_out_st;
endmodule

### dv/usd_checker.sv
module usd_checker
    import usd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    usd_in_if           i_in_mon,
    usd_out_if          i_out_mon,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct {
        logic [20:0] code_point;
        t_status     status;
    } t_symbol;

    t_symbol     due_q[$];
    int          mismatches = 0;

    // Register copies
    logic [2:0]  reg_enc;
    logic        reg_bom;

    // Sequence state of the predicted decoder
    logic [31:0] seq_bytes;
    int          seq_count;
    int          seq_len;
    t_enc        live_enc;
    logic        awaiting_first;

    assign o_mismatches = mismatches;

    task automatic report(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic t_enc code_to_enc(input logic [2:0] code);
        return (code > 3'd4) ? ENC_UTF8 : t_enc'(code);
    endfunction

    function automatic void clear_seq();
        seq_bytes = '0;
        seq_count = 0;
        seq_len   = 0;
    endfunction

    // Drop the partial sequence and reload the byte order from the register
    function automatic void restart_decoder();
        clear_seq();
        live_enc       = code_to_enc(reg_enc);
        awaiting_first = 1'b1;
    endfunction

    function automatic void push_error(input t_status st);
        clear_seq();
        awaiting_first = 1'b0;
        due_q.push_back('{code_point: 21'd0, status: st});
    endfunction

    // A byte order mark is swallowed only as the first symbol of a stream
    function automatic void push_char(input logic [31:0] cp);
        clear_seq();
        if (awaiting_first) begin
            awaiting_first = 1'b0;
            if (reg_bom) begin
                if (cp == {16'd0, BOM_NATIVE}) return;
                if (cp == {16'd0, BOM_SWAPPED} && live_enc != ENC_UTF8) begin
                    case (live_enc)
                        ENC_U16BE: live_enc = ENC_U16LE;
                        ENC_U16LE: live_enc = ENC_U16BE;
                        ENC_U32BE: live_enc = ENC_U32LE;
                        default:   live_enc = ENC_U32BE;
                    endcase
                    return;
                end
            end
        end
        due_q.push_back('{code_point: cp[20:0], status: ST_CHAR});
    endfunction

    function automatic void take_utf8(input logic [7:0] b);
        logic [7:0]  lead;
        logic [7:0]  second;
        logic [31:0] cp;
        if (seq_count == 0) begin
            casez (b)
                8'b0???????: begin
                    push_char({24'd0, b});
                    return;
                end
                8'b110?????: seq_len = 2;
                8'b1110????: seq_len = 3;
                8'b11110???: seq_len = 4;
                default: begin
                    push_error(ST_BAD_LEAD);
                    return;
                end
            endcase
            seq_bytes = {24'd0, b};
            seq_count = 1;
            return;
        end
        // A byte that is not a continuation is consumed with the error
        if (b[7:6] != 2'b10) begin
            push_error(ST_BAD_TRAIL);
            return;
        end
        seq_bytes = {seq_bytes[23:0], b};
        seq_count++;
        if (seq_count < seq_len) return;
        lead   = seq_bytes[8*(seq_len-1) +: 8];
        second = seq_bytes[8*(seq_len-2) +: 8];
        // Out-of-range values are flagged ahead of over-long forms
        if ((lead == 8'hED && second > 8'h9F) || (lead == 8'hF4 && second > 8'h8F) ||
            lead > 8'hF4) begin
            push_error(ST_BAD_CP);
        end else if (lead < 8'hC2 || (lead == 8'hE0 && second < 8'hA0) ||
                     (lead == 8'hF0 && second < 8'h90)) begin
            push_error(ST_OVERLONG);
        end else begin
            case (seq_len)
                2: cp = {21'd0, lead[4:0], seq_bytes[5:0]};
                3: cp = {16'd0, lead[3:0], seq_bytes[13:8], seq_bytes[5:0]};
                default: cp = {11'd0, lead[2:0], seq_bytes[21:16], seq_bytes[13:8],
                               seq_bytes[5:0]};
            endcase
            push_char(cp);
        end
    endfunction

    function automatic void take_utf16(input logic [7:0] b, input bit little);
        logic [15:0] hi;
        logic [15:0] lo;
        if (seq_count == 0) begin
            seq_len   = 2;
            seq_bytes = '0;
        end
        seq_bytes = {seq_bytes[23:0], b};
        seq_count++;
        if (seq_count < seq_len) return;
        if (seq_count == 2) begin
            hi = little ? {seq_bytes[7:0], seq_bytes[15:8]} : seq_bytes[15:0];
            if (hi >= 16'hDC00 && hi <= 16'hDFFF) begin
                push_error(ST_BAD_LEAD);
            end else if (hi >= 16'hD800 && hi <= 16'hDBFF) begin
                // High surrogate: wait for its partner
                seq_len = 4;
            end else begin
                push_char({16'd0, hi});
            end
            return;
        end
        hi = little ? {seq_bytes[23:16], seq_bytes[31:24]} : seq_bytes[31:16];
        lo = little ? {seq_bytes[7:0], seq_bytes[15:8]} : seq_bytes[15:0];
        if (lo < 16'hDC00 || lo > 16'hDFFF) begin
            push_error(ST_BAD_TRAIL);
        end else begin
            push_char(32'h10000 + {12'd0, hi[9:0], lo[9:0]});
        end
    endfunction

    function automatic void take_utf32(input logic [7:0] b, input bit little);
        logic [31:0] v;
        if (seq_count == 0) begin
            seq_len   = 4;
            seq_bytes = '0;
        end
        seq_bytes = {seq_bytes[23:0], b};
        seq_count++;
        if (seq_count < seq_len) return;
        v = little ? {seq_bytes[7:0], seq_bytes[15:8], seq_bytes[23:16], seq_bytes[31:24]}
                   : seq_bytes;
        if (v > {11'd0, CP_MAX} || (v >= 32'hD800 && v <= 32'hDFFF)) begin
            push_error(ST_BAD_CP);
        end else begin
            push_char(v);
        end
    endfunction

    function automatic void take_item(input logic [7:0] b, input logic eos);
        t_status st;
        if (eos) begin
            st = (seq_count != 0) ? ST_TRUNC : ST_END;
            restart_decoder();
            due_q.push_back('{code_point: 21'd0, status: st});
            return;
        end
        case (live_enc)
            ENC_U16BE: take_utf16(b, 1'b0);
            ENC_U16LE: take_utf16(b, 1'b1);
            ENC_U32BE: take_utf32(b, 1'b0);
            ENC_U32LE: take_utf32(b, 1'b1);
            default:   take_utf8(b);
        endcase
    endfunction

    // Register writes first, then the result transfer, then the byte transfer
    always @(posedge i_clk) begin : watch
        t_symbol want;
        if (!i_rst_n) begin
            reg_enc = ENC_UTF8;
            reg_bom = 1'b0;
            restart_decoder();
            due_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_ENCODING) begin
                    reg_enc = i_pwdata[2:0];
                    restart_decoder();
                end else begin
                    reg_bom = i_pwdata[0];
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (due_q.size() == 0) begin
                    report($sformatf("result with nothing due: cp %0h status %0d",
                                     i_out_mon.code_point, i_out_mon.status));
                end else begin
                    want = due_q.pop_front();
                    if (i_out_mon.code_point !== want.code_point) begin
                        report($sformatf("code_point %0h, predicted %0h (status %0d)",
                                         i_out_mon.code_point, want.code_point,
                                         want.status));
                    end
                    if (i_out_mon.status !== want.status) begin
                        report($sformatf("status %0d, predicted %0d (cp %0h)",
                                         i_out_mon.status, want.status,
                                         want.code_point));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                take_item(i_in_mon.data_byte, i_in_mon.end_of_stream);
            end
        end
        o_outstanding <= due_q.size();
    end

endmodule

### dv/tb.sv
module tb;
    import usd_pkg::*;

    localparam int IDLE_PCT      = 18;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 44;
    localparam int QUIET_PHASE   = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 32;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [2:0] ADDR_ENCODING = {REG_ENCODING, 2'b00};
    localparam logic [2:0] ADDR_BOM      = {REG_BOM, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          idle_pct = IDLE_PCT;
    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          sent_count = 0;

    // What the stream generator believes the decoder is set to
    logic [2:0]  cfg_enc;
    logic        cfg_bom;
    t_enc        gen_enc;
    bit          fresh;

    usd_in_if  in_ch ();
    usd_out_if out_ch ();

    unicode_stream_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    usd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Abandon a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL unicode_stream_decoder");
            $finish;
        end
    end

    function automatic t_enc native_enc();
        return (cfg_enc > 3'd4) ? ENC_UTF8 : t_enc'(cfg_enc);
    endfunction

    // Leaves psel high so that back-to-back writes need no release in between
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic configure(input logic [2:0] code, input logic bom);
        write_reg(ADDR_ENCODING, {29'd0, code});
        write_reg(ADDR_BOM, {31'd0, bom});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_enc = code;
        cfg_bom = bom;
        gen_enc = native_enc();
        fresh   = 1'b1;
    endtask

    task automatic send_item(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_count++;
    endtask

    task automatic send_seq(input logic [7:0] seq[$]);
        foreach (seq[i]) send_item(seq[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
        gen_enc = native_enc();
        fresh   = 1'b1;
    endtask

    // Drop valid, drain every due result, then let the pipeline settle
    task automatic hold_off();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void put_unit(input logic [31:0] u, input int n,
                                     ref logic [7:0] q[$]);
        bit little;
        little = (gen_enc == ENC_U16LE || gen_enc == ENC_U32LE);
        for (int i = 0; i < n; i++) begin
            q.push_back(little ? u[8*i +: 8] : u[8*(n-1-i) +: 8]);
        end
    endfunction

    // len stretches a UTF-8 form beyond its shortest length
    function automatic void encode(input logic [31:0] v, input int len,
                                   ref logic [7:0] q[$]);
        logic [19:0] w;
        int          shortest;
        case (gen_enc)
            ENC_U16BE, ENC_U16LE: begin
                if (v < 32'h10000) begin
                    put_unit(v, 2, q);
                end else begin
                    w = 20'(v - 32'h10000);
                    put_unit({16'd0, 6'b110110, w[19:10]}, 2, q);
                    put_unit({16'd0, 6'b110111, w[9:0]}, 2, q);
                end
            end
            ENC_U32BE, ENC_U32LE: put_unit(v, 4, q);
            default: begin
                shortest = (v < 32'h80) ? 1 : (v < 32'h800) ? 2 : (v < 32'h10000) ? 3 : 4;
                if (len < shortest) len = shortest;
                case (len)
                    1: q.push_back(v[7:0]);
                    2: begin
                        q.push_back({3'b110, v[10:6]});
                        q.push_back({2'b10, v[5:0]});
                    end
                    3: begin
                        q.push_back({4'b1110, v[15:12]});
                        q.push_back({2'b10, v[11:6]});
                        q.push_back({2'b10, v[5:0]});
                    end
                    default: begin
                        q.push_back({5'b11110, v[20:18]});
                        q.push_back({2'b10, v[17:12]});
                        q.push_back({2'b10, v[11:6]});
                        q.push_back({2'b10, v[5:0]});
                    end
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] random_scalar();
        logic [31:0] v;
        case ($urandom_range(4))
            0: v = $urandom_range(32'h7F);
            1: v = $urandom_range(32'h80, 32'h7FF);
            2: v = $urandom_range(32'h800, 32'hFFFF);
            3: v = $urandom_range(32'h10000, 32'h10FFFF);
            default: begin
                case ($urandom_range(5))
                    0: v = 32'h0;
                    1: v = 32'h7F;
                    2: v = 32'hFFFF;
                    3: v = 32'h10FFFF;
                    4: v = {16'd0, BOM_NATIVE};
                    default: v = {16'd0, BOM_SWAPPED};
                endcase
            end
        endcase
        // Move surrogates out of the way
        if (v >= 32'hD800 && v <= 32'hDFFF) v = v + 32'h800;
        return v;
    endfunction

    // Surrogates and values beyond the last scalar
    function automatic logic [31:0] refused_value();
        logic [31:0] v;
        case (gen_enc)
            ENC_UTF8:
                v = $urandom_range(1) ? 32'($urandom_range(32'hD800, 32'hDFFF))
                                      : 32'($urandom_range(32'h110000, 32'h1FFFFF));
            ENC_U16BE, ENC_U16LE: v = $urandom_range(32'hD800, 32'hDFFF);
            default:
                v = $urandom_range(1) ? 32'($urandom_range(32'hD800, 32'hDFFF)) : $urandom();
        endcase
        return v;
    endfunction

    // Mostly well-formed symbols, some refused values, over-long, cut short or noise
    task automatic send_symbol();
        logic [7:0]  seq[$];
        logic [31:0] v;
        int          pick;
        int          len;
        pick = $urandom_range(99);
        v    = random_scalar();
        len  = 0;
        if (pick >= 95) begin
            repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(255)));
        end else begin
            if (pick >= 75 && pick < 85) v = refused_value();
            else if (pick >= 85 && pick < 90) len = $urandom_range(2, 4);
            encode(v, len, seq);
            if (pick >= 90 && seq.size() > 1) void'(seq.pop_back());
        end
        send_seq(seq);
        fresh = 1'b0;
    endtask

    task automatic send_stream();
        logic [7:0]  seq[$];
        logic [31:0] mark;
        int          count;
        count = $urandom_range(1, 12);
        // Optionally open with a byte order mark of either sense
        if ($urandom_range(3) == 0) begin
            mark = $urandom_range(1) ? {16'd0, BOM_NATIVE} : {16'd0, BOM_SWAPPED};
            encode(mark, 0, seq);
            send_seq(seq);
            if (fresh && cfg_bom && mark == {16'd0, BOM_SWAPPED} && gen_enc != ENC_UTF8) begin
                case (gen_enc)
                    ENC_U16BE: gen_enc = ENC_U16LE;
                    ENC_U16LE: gen_enc = ENC_U16BE;
                    ENC_U32BE: gen_enc = ENC_U32LE;
                    default:   gen_enc = ENC_U32BE;
                endcase
            end
            fresh = 1'b0;
        end
        repeat (count) send_symbol();
        if ($urandom_range(99) < 85) send_end();
    endtask

    initial begin
        logic [7:0] seq[$];
        int         start;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.data_byte     <= '0;
        in_ch.end_of_stream <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // UTF-8: dropped byte order mark, byte extremes, over-long, surrogate,
        // bad trail, largest scalar, then a cut-short sequence closed by the end mark
        configure(ENC_UTF8, 1'b1);
        seq = {8'hEF, 8'hBB, 8'hBF, 8'h00, 8'hFF, 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80,
               8'hE2, 8'h41, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC3};
        send_seq(seq);
        send_end();
        hold_off();

        // UTF-16: a swapped mark flips the byte order for the rest of the stream
        configure(ENC_U16BE, 1'b1);
        seq = {8'hFF, 8'hFE, 8'h41, 8'h00};
        send_seq(seq);
        send_end();

        // Walk every encoding code, then random settings
        for (int p = 0; p < PHASES; p++) begin
            hold_off();
            idle_pct = (p == QUIET_PHASE || p == QUIET_PHASE + 1) ? 0 : IDLE_PCT;
            configure(p < 8 ? p[2:0] : 3'($urandom_range(7)),
                      p < 8 ? p[0] : 1'($urandom_range(1)));
            start = sent_count;
            while (sent_count - start < PHASE_ITEMS) send_stream();
        end

        hold_off();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS unicode_stream_decoder");
        end else begin
            $display("FAIL unicode_stream_decoder");
        end
        $finish;
    end

endmodule

### unicode_stream_decoder.f
+incdir+hdl
hdl/usd_pkg.sv
hdl/usd_if.sv
hdl/usd_front.sv
hdl/usd_fifo.sv
hdl/usd_back.sv
hdl/unicode_stream_decoder.sv
dv/usd_checker.sv
dv/tb.sv
